/* hdl/diff_drive_pose_integrator_top_assert.svh */
// assertion macros for the pose integrator
`ifndef DIFF_DRIVE_POSE_INTEGRATOR_TOP_ASSERT_SVH
`define DIFF_DRIVE_POSE_INTEGRATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DDPI_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`define DDPI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DDPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DDPI_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define DDPI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DDPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/ddpi_pkg.sv */
package ddpi_pkg;

  localparam int unsigned MUL_A_W    = 48;
  localparam int unsigned MUL_B_W    = 32;
  localparam int unsigned MUL_RAW_W  = MUL_A_W + 1 + MUL_B_W;
  localparam int unsigned MUL_STEP_W = 6;

  localparam int unsigned CORDIC_W   = 34;

  localparam logic [25:0] GYRO_GAIN   = 26'd53641946;
  localparam logic [29:0] INV_TWO_PI  = 30'd683565276;
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

  localparam logic [7:0] DEN_AUTO   = 8'd255;
  localparam logic [7:0] DEN_MANUAL = 8'd100;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED = 2'd0,
    CFG_INV_BASE  = 2'd1,
    CFG_TIME_STEP = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                  start;
    logic [MUL_STEP_W-1:0] steps;
  } mul_cmd_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* hdl/diff_drive_pose_integrator_top.sv */
// channel   direction  transfer when                     payload
// s_axis    in         s_axis_tvalid & s_axis_tready     tick item, tuser = operation
// m_axis    out        m_axis_tvalid & m_axis_tready     candidate pose and rates
// cfg       in         cfg_valid_i & cfg_ready_o         register index and data
//
// an advance is paced by the bit-serial multiplier (one multiplier bit per cycle
// over nine products) and two 24-step divisions; a set-pose goes straight to
// the output state. the cordic runs alongside the multiplies.
// reset loads the register defaults and clears pose, mode and gyro state.
// a result waiting in the output register stalls only the next finishing item.
`include "diff_drive_pose_integrator_top_assert.svh"

module diff_drive_pose_integrator_top #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // button_level, key_level, left_pwm[7:0], left_reverse, right_pwm[7:0],
  // right_reverse, left_stick[7:0], right_stick[7:0], pose_x[31:0],
  // pose_y[31:0], pose_heading[31:0], zero fill
  input  logic [135:0]  s_axis_tdata,
  // operation
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // next_x[31:0], next_y[31:0], next_heading[31:0], forward_speed[24:0],
  // turn_rate[31:0], gyro_reading[15:0], auto_mode, zero fill
  output logic [175:0]  m_axis_tdata,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i
);
  import ddpi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LMUL, ST_LDIV, ST_RMUL, ST_RDIV, ST_SUM, ST_TURN, ST_GYRO,
    ST_DIST, ST_XMUL, ST_YMUL, ST_HMUL1, ST_HMUL2, ST_OUT
  } state_e;

  localparam logic signed [7:0] STICK_MAX = 8'sd100;

  state_e state_q;

  logic [23:0] max_speed_q, inv_base_q;
  logic [15:0] time_step_q;
  logic [31:0] pos_x_q, pos_y_q, heading_q;
  logic        auto_q, btn_q, key_q;
  logic signed [15:0] gyro_q;

  logic        pwm_any_q, neg_l_q, neg_r_q, d_neg_q;
  logic [7:0]  mag_l_q, mag_r_q;
  logic signed [24:0] lv_q, rv_q, fwd_q;
  logic [25:0] diff_mag_q;
  logic        diff_neg_q;
  logic signed [31:0] turn_q;
  logic [31:0] tm_q, nx_q, ny_q, nh_q;
  logic [23:0] d_mag_q;
  logic [47:0] hm_q;

  logic [7:0]  rem_q;
  logic [23:0] dv_q;
  logic [4:0]  dcnt_q;
  logic        start_q;

  logic         m_valid_q;
  logic [175:0] m_data_q;

  logic s_acc, op, btn, key, toggle, auto_nx;
  logic [7:0] lpwm, rpwm, lmag_st, rmag_st;
  logic signed [7:0] lstick, rstick;
  logic lneg_st, rneg_st;

  mul_cmd_t mul_cmd;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic                 mul_done;
  logic [MUL_RAW_W-1:0] mul_raw;

  logic cordic_done;
  logic signed [CORDIC_W-1:0] cos_v, sin_v, cneg, sneg;
  logic [31:0] cos_mag, sin_mag;

  logic [8:0]  trial;
  logic        ge;
  logic [7:0]  den, rem_nx;
  logic [23:0] dv_nx;
  logic signed [24:0] q_signed;

  logic signed [25:0] sum26, sum_adj, diff26, diff_negv;
  logic signed [24:0] fwd_negv;
  logic [23:0] fwd_mag;
  logic [32:0] tmag;
  logic [25:0] gmag;
  logic [31:0] prod32, dh;
  logic [31:0] delta;

  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign op     = s_axis_tuser[0];
  assign btn    = s_axis_tdata[0];
  assign key    = s_axis_tdata[1];
  assign lpwm   = s_axis_tdata[9:2];
  assign rpwm   = s_axis_tdata[18:11];
  assign lstick = $signed(s_axis_tdata[27:20]);
  assign rstick = $signed(s_axis_tdata[35:28]);
  assign toggle = (btn && !btn_q) || (key && !key_q);
  assign auto_nx = auto_q ^ toggle;

  // stick saturation to the percent range
  always_comb begin
    if (lstick > STICK_MAX) begin
      lneg_st = 1'b0; lmag_st = 8'd100;
    end else if (lstick < -STICK_MAX) begin
      lneg_st = 1'b1; lmag_st = 8'd100;
    end else begin
      lneg_st = lstick[7]; lmag_st = lstick[7] ? 8'(-lstick) : 8'(lstick);
    end
    if (rstick > STICK_MAX) begin
      rneg_st = 1'b0; rmag_st = 8'd100;
    end else if (rstick < -STICK_MAX) begin
      rneg_st = 1'b1; rmag_st = 8'd100;
    end else begin
      rneg_st = rstick[7]; rmag_st = rstick[7] ? 8'(-rstick) : 8'(rstick);
    end
  end

  // restoring division step, one quotient bit per cycle
  assign den      = auto_q ? DEN_AUTO : DEN_MANUAL;
  assign trial    = {rem_q, dv_q[23]};
  assign ge       = trial >= {1'b0, den};
  assign rem_nx   = ge ? 8'(trial - {1'b0, den}) : trial[7:0];
  assign dv_nx    = {dv_q[22:0], ge};
  assign q_signed = (state_q == ST_LDIV ? neg_l_q : neg_r_q) ?
                    -$signed({1'b0, dv_nx}) : $signed({1'b0, dv_nx});

  assign sum26     = 26'(lv_q) + 26'(rv_q);
  assign sum_adj   = sum26 + (sum26[25] ? 26'sd1 : 26'sd0);
  assign diff26    = 26'(rv_q) - 26'(lv_q);
  assign diff_negv = -diff26;
  assign fwd_negv  = -fwd_q;
  assign fwd_mag   = fwd_q[24] ? fwd_negv[23:0] : fwd_q[23:0];

  assign cneg    = -cos_v;
  assign sneg    = -sin_v;
  assign cos_mag = cos_v[CORDIC_W-1] ? cneg[31:0] : cos_v[31:0];
  assign sin_mag = sin_v[CORDIC_W-1] ? sneg[31:0] : sin_v[31:0];

  assign tmag   = mul_raw[24 +: 33];
  assign gmag   = mul_raw[38 +: 26];
  assign prod32 = mul_raw[38 +: 32];
  assign dh     = mul_raw[34 +: 32];
  assign delta  = ((state_q == ST_XMUL) ? (d_neg_q ^ cos_v[CORDIC_W-1])
                                        : (d_neg_q ^ sin_v[CORDIC_W-1])) ? -prod32 : prod32;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_cmd.start = start_q;
    mul_cmd.steps = '0;
    unique case (state_q)
      ST_LMUL: begin
        mul_a = MUL_A_W'(max_speed_q); mul_b = MUL_B_W'(mag_l_q); mul_cmd.steps = 6'd8;
      end
      ST_RMUL: begin
        mul_a = MUL_A_W'(max_speed_q); mul_b = MUL_B_W'(mag_r_q); mul_cmd.steps = 6'd8;
      end
      ST_TURN: begin
        mul_a = MUL_A_W'(diff_mag_q); mul_b = MUL_B_W'(inv_base_q); mul_cmd.steps = 6'd24;
      end
      ST_GYRO: begin
        mul_a = MUL_A_W'(tm_q); mul_b = MUL_B_W'(GYRO_GAIN); mul_cmd.steps = 6'd26;
      end
      ST_DIST: begin
        mul_a = MUL_A_W'(fwd_mag); mul_b = MUL_B_W'(time_step_q); mul_cmd.steps = 6'd16;
      end
      ST_XMUL: begin
        mul_a = MUL_A_W'(cos_mag); mul_b = MUL_B_W'(d_mag_q); mul_cmd.steps = 6'd24;
      end
      ST_YMUL: begin
        mul_a = MUL_A_W'(sin_mag); mul_b = MUL_B_W'(d_mag_q); mul_cmd.steps = 6'd24;
      end
      ST_HMUL1: begin
        mul_a = MUL_A_W'(tm_q); mul_b = MUL_B_W'(time_step_q); mul_cmd.steps = 6'd16;
      end
      ST_HMUL2: begin
        mul_a = hm_q; mul_b = MUL_B_W'(INV_TWO_PI); mul_cmd.steps = 6'd30;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  ddpi_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .raw_o  (mul_raw)
  );

  ddpi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_acc && !op),
    .angle_i (heading_q),
    .done_o  (cordic_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= 24'd65536;
      inv_base_q  <= 24'd327680;
      time_step_q <= 16'd1092;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_SPEED: max_speed_q <= cfg_data_i;
        CFG_INV_BASE:  inv_base_q  <= cfg_data_i;
        CFG_TIME_STEP: time_step_q <= cfg_data_i[15:0];
        default:       max_speed_q <= max_speed_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      heading_q  <= '0;
      auto_q     <= 1'b0;
      btn_q      <= 1'b0;
      key_q      <= 1'b0;
      gyro_q     <= '0;
      start_q    <= 1'b0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      pwm_any_q  <= 1'b0;
      neg_l_q    <= 1'b0;
      neg_r_q    <= 1'b0;
      d_neg_q    <= 1'b0;
      mag_l_q    <= '0;
      mag_r_q    <= '0;
      lv_q       <= '0;
      rv_q       <= '0;
      fwd_q      <= '0;
      diff_mag_q <= '0;
      diff_neg_q <= 1'b0;
      turn_q     <= '0;
      tm_q       <= '0;
      nx_q       <= '0;
      ny_q       <= '0;
      nh_q       <= '0;
      d_mag_q    <= '0;
      hm_q       <= '0;
      rem_q      <= '0;
      dv_q       <= '0;
      dcnt_q     <= '0;
    end else begin
      start_q <= 1'b0;
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            if (op) begin
              pos_x_q   <= s_axis_tdata[67:36];
              pos_y_q   <= s_axis_tdata[99:68];
              heading_q <= s_axis_tdata[131:100];
              nx_q      <= s_axis_tdata[67:36];
              ny_q      <= s_axis_tdata[99:68];
              nh_q      <= s_axis_tdata[131:100];
              fwd_q     <= '0;
              turn_q    <= '0;
              state_q   <= ST_OUT;
            end else begin
              auto_q    <= auto_nx;
              btn_q     <= btn;
              key_q     <= key;
              pwm_any_q <= (lpwm != '0) || (rpwm != '0);
              mag_l_q   <= auto_nx ? lpwm : lmag_st;
              mag_r_q   <= auto_nx ? rpwm : rmag_st;
              neg_l_q   <= auto_nx ? s_axis_tdata[10] : lneg_st;
              neg_r_q   <= auto_nx ? s_axis_tdata[19] : rneg_st;
              start_q   <= 1'b1;
              state_q   <= ST_LMUL;
            end
          end
        end
        ST_LMUL, ST_RMUL: begin
          if (mul_done) begin
            rem_q   <= mul_raw[55:48];
            dv_q    <= mul_raw[47:24];
            dcnt_q  <= '0;
            state_q <= (state_q == ST_LMUL) ? ST_LDIV : ST_RDIV;
          end
        end
        ST_LDIV, ST_RDIV: begin
          rem_q  <= rem_nx;
          dv_q   <= dv_nx;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 5'd23) begin
            if (state_q == ST_LDIV) begin
              lv_q    <= q_signed;
              start_q <= 1'b1;
              state_q <= ST_RMUL;
            end else begin
              rv_q    <= q_signed;
              state_q <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          fwd_q      <= 25'(sum_adj >>> 1);
          diff_neg_q <= diff26[25];
          diff_mag_q <= diff26[25] ? diff_negv : diff26;
          start_q    <= 1'b1;
          state_q    <= ST_TURN;
        end
        ST_TURN: begin
          if (mul_done) begin
            if (diff_neg_q) begin
              if (tmag > 33'h0_8000_0000) begin
                turn_q <= 32'sh8000_0000;
                tm_q   <= 32'h8000_0000;
              end else begin
                turn_q <= -$signed(tmag[31:0]);
                tm_q   <= tmag[31:0];
              end
            end else if (tmag > 33'h0_7FFF_FFFF) begin
              turn_q <= 32'sh7FFF_FFFF;
              tm_q   <= 32'h7FFF_FFFF;
            end else begin
              turn_q <= $signed(tmag[31:0]);
              tm_q   <= tmag[31:0];
            end
            start_q <= 1'b1;
            state_q <= ST_GYRO;
          end
        end
        ST_GYRO: begin
          if (mul_done) begin
            if (pwm_any_q) begin
              if (turn_q[31]) begin
                gyro_q <= (gmag > 26'd32768) ? 16'sh8000 : 16'(-$signed(gmag));
              end else begin
                gyro_q <= (gmag > 26'd32767) ? 16'sh7FFF : $signed(gmag[15:0]);
              end
            end
            start_q <= 1'b1;
            state_q <= ST_DIST;
          end
        end
        ST_DIST: begin
          if (mul_done) begin
            d_mag_q <= mul_raw[32 +: 24];
            d_neg_q <= fwd_q[24];
            start_q <= 1'b1;
            state_q <= ST_XMUL;
          end
        end
        ST_XMUL: begin
          if (mul_done) begin
            nx_q    <= pos_x_q + delta;
            start_q <= 1'b1;
            state_q <= ST_YMUL;
          end
        end
        ST_YMUL: begin
          if (mul_done) begin
            ny_q    <= pos_y_q + delta;
            start_q <= 1'b1;
            state_q <= ST_HMUL1;
          end
        end
        ST_HMUL1: begin
          if (mul_done) begin
            hm_q    <= mul_raw[16 +: 48];
            start_q <= 1'b1;
            state_q <= ST_HMUL2;
          end
        end
        ST_HMUL2: begin
          if (mul_done) begin
            nh_q    <= heading_q + (turn_q[31] ? -dh : dh);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {6'b0, auto_q, gyro_q, turn_q, fwd_q, nh_q, ny_q, nx_q};
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  `DDPI_ASSERT_IMPL(a_cordic_ready, clk_i, rst_ni, state_q == ST_XMUL, cordic_done)
  `DDPI_ASSERT_NEVER(a_mul_idle, clk_i, rst_ni, mul_done && (state_q == ST_IDLE || state_q == ST_OUT))
  `DDPI_ASSERT_NEXT(a_item_leaves_idle, clk_i, rst_ni, s_acc, state_q != ST_IDLE)

endmodule

/* hdl/ddpi_mul.sv */
module ddpi_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ddpi_pkg::mul_cmd_t           cmd_i,
  input  logic [ddpi_pkg::MUL_A_W-1:0] a_i,
  input  logic [ddpi_pkg::MUL_B_W-1:0] b_i,
  output logic                         done_o,
  output logic [ddpi_pkg::MUL_RAW_W-1:0] raw_o
);
  import ddpi_pkg::*;

  logic [MUL_A_W-1:0]    a_q;
  logic [MUL_A_W:0]      hi_q;
  logic [MUL_B_W-1:0]    lo_q;
  logic [MUL_STEP_W-1:0] cnt_q;
  logic                  busy_q, done_q;
  logic [MUL_A_W:0]      sum;

  // shift-add, one multiplier bit per cycle
  assign sum = hi_q + {1'b0, (lo_q[0] ? a_q : '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        a_q    <= a_i;
        hi_q   <= '0;
        lo_q   <= b_i;
        cnt_q  <= cmd_i.steps;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        hi_q  <= {1'b0, sum[MUL_A_W:1]};
        lo_q  <= {sum[0], lo_q[MUL_B_W-1:1]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MUL_STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign raw_o  = {hi_q, lo_q};

endmodule

/* hdl/ddpi_cordic.sv */
module ddpi_cordic #(
  parameter int unsigned STEPS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [31:0]                          angle_i,
  output logic                                 done_o,
  output logic signed [ddpi_pkg::CORDIC_W-1:0] cos_o,
  output logic signed [ddpi_pkg::CORDIC_W-1:0] sin_o
);
  import ddpi_pkg::*;

  localparam int unsigned CW = $clog2(STEPS + 1);

  logic signed [CORDIC_W-1:0] x_q, y_q, xs, ys;
  logic signed [31:0]         z_q, ang;
  logic [1:0]                 quad_q;
  logic [CW-1:0]              cnt_q;
  logic                       busy_q, done_q;
  logic [31:0]                rot;

  assign rot = angle_i + 32'h2000_0000;
  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign ang = $signed(atan_bam(5'(cnt_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quad_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      if (start_i) begin
        x_q    <= CORDIC_START;
        y_q    <= '0;
        z_q    <= $signed({2'b00, rot[29:0]}) - 32'sh2000_0000;
        quad_q <= rot[31:30];
        cnt_q  <= '0;
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end else if (busy_q) begin
        if (!z_q[31]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - ang;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + ang;
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // fold the quadrant back in
  always_comb begin
    unique case (quad_q)
      2'd0: begin cos_o = x_q;  sin_o = y_q;  end
      2'd1: begin cos_o = -y_q; sin_o = x_q;  end
      2'd2: begin cos_o = -x_q; sin_o = -y_q; end
      2'd3: begin cos_o = y_q;  sin_o = -x_q; end
    endcase
  end

  assign done_o = done_q;

endmodule

/* bench/diff_drive_pose_integrator_top_test.sv */
`timescale 1ns / 1ps

module diff_drive_pose_integrator_top_test;
  import ddpi_pkg::*;

  localparam logic OP_ADVANCE  = 1'b0;
  localparam logic OP_SET_POSE = 1'b1;
  localparam int   IDLE_LIMIT  = 3000;
  localparam int   RANDOM_ITEMS = 280;

  localparam logic [31:0] ANGLE_STEP [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    logic        op;
    logic        btn;
    logic        key;
    logic [7:0]  lpwm;
    logic        lrev;
    logic [7:0]  rpwm;
    logic        rrev;
    logic [7:0]  lstick;
    logic [7:0]  rstick;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] ph;
  } tick_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] h;
    logic [24:0] fwd;
    logic [31:0] turn;
    logic [15:0] gyro;
    logic        mode;
  } pose_t;

  typedef struct {
    tick_t t;
    bit    typed;
    pose_t r;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [135:0]  s_axis_tdata = '0;
  logic [0:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [175:0]  m_axis_tdata;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i = '0;
  logic [23:0]   cfg_data_i = '0;

  // predictor state and registers
  longint      max_speed_q, inv_base_q, time_step_q;
  logic [31:0] pos_x_q, pos_y_q, heading_q;
  logic        auto_q, btn_was_q, key_was_q;
  logic [15:0] gyro_q;

  pose_t pose_q[$];
  row_t  rows[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    tx_burst = 0, rx_burst = 0;
  int    rx_stall = 0;

  diff_drive_pose_integrator_top dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint trunc_shift(longint v, int s);
    longint m;
    m = (v < 0 ? -v : v) >> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wheel(longint mag, longint den, bit neg);
    longint m;
    m = (mag * max_speed_q) / den;
    return neg ? -m : m;
  endfunction

  function automatic pose_t predict_pose(tick_t t);
    pose_t  r;
    longint lv, rv, fwd, turn, d, c, s, x, y, z, hp, xs, ys, ls, rs;
    logic [63:0] hm, hd;
    logic [31:0] ra, dh;
    fwd = 0;
    turn = 0;
    if (t.op == OP_SET_POSE) begin
      pos_x_q = t.px;
      pos_y_q = t.py;
      heading_q = t.ph;
      r.x = t.px;
      r.y = t.py;
      r.h = t.ph;
    end else begin
      if ((t.btn && !btn_was_q) || (t.key && !key_was_q)) auto_q = !auto_q;
      btn_was_q = t.btn;
      key_was_q = t.key;
      if (auto_q) begin
        lv = wheel(t.lpwm, 255, t.lrev);
        rv = wheel(t.rpwm, 255, t.rrev);
      end else begin
        ls = clamp(longint'($signed(t.lstick)), -100, 100);
        rs = clamp(longint'($signed(t.rstick)), -100, 100);
        lv = wheel(ls < 0 ? -ls : ls, 100, ls < 0);
        rv = wheel(rs < 0 ? -rs : rs, 100, rs < 0);
      end
      fwd = (rv + lv) / 2;
      turn = clamp(trunc_shift((rv - lv) * inv_base_q, 16), -64'sd2147483648, 64'sd2147483647);
      if (t.lpwm != 0 || t.rpwm != 0)
        gyro_q = 16'(clamp(trunc_shift(turn * 64'sd53641946, 32), -32768, 32767));
      // quadrant removed, residual rotated
      ra = heading_q + 32'h20000000;
      z = longint'({34'd0, ra[29:0]}) - 64'sh20000000;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'(ANGLE_STEP[i]);
        end else begin
          x = x + ys; y = y - xs; z = z + longint'(ANGLE_STEP[i]);
        end
      end
      case (ra[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      d = trunc_shift(fwd * time_step_q, 16);
      r.x = pos_x_q + 32'(trunc_shift(d * c, 30));
      r.y = pos_y_q + 32'(trunc_shift(d * s, 30));
      hp = turn * time_step_q;
      hm = hp < 0 ? -hp : hp;
      hd = (hm >> 32) * 64'd683565276 + (((hm & 64'hFFFFFFFF) * 64'd683565276) >> 32);
      dh = hd[31:0];
      if (hp < 0) dh = -dh;
      r.h = heading_q + dh;
    end
    r.fwd = fwd[24:0];
    r.turn = turn[31:0];
    r.gyro = gyro_q;
    r.mode = auto_q;
    return r;
  endfunction

  function automatic tick_t mk_tick(logic op, logic btn, logic key, logic [7:0] lp, logic lr,
                                    logic [7:0] rp, logic rr, logic [7:0] ls, logic [7:0] rs,
                                    logic [31:0] px, logic [31:0] py, logic [31:0] ph);
    tick_t t;
    t = '{op, btn, key, lp, lr, rp, rr, ls, rs, px, py, ph};
    return t;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.op = ($urandom_range(0, 9) == 0) ? OP_SET_POSE : OP_ADVANCE;
    t.btn = $urandom_range(0, 3) == 0;
    t.key = $urandom_range(0, 5) == 0;
    t.lpwm = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
    t.rpwm = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
    if ($urandom_range(0, 9) == 0) t.lpwm = 8'd255;
    t.lrev = 1'($urandom);
    t.rrev = 1'($urandom);
    t.lstick = 8'($urandom);
    t.rstick = 8'($urandom);
    t.px = $urandom;
    t.py = $urandom;
    t.ph = $urandom;
    return t;
  endfunction

  function automatic int gap_len(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task automatic send_tick(tick_t t, bit typed, pose_t want);
    pose_t p;
    int    gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= t.op;
    s_axis_tdata <= {4'd0, t.ph, t.py, t.px, t.rstick, t.lstick, t.rrev, t.rpwm, t.lrev,
                     t.lpwm, t.key, t.btn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = predict_pose(t);
    pose_q.push_back(typed ? want : p);
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    gap = gap_len(tx_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] value);
    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MAX_SPEED: max_speed_q = value;
      CFG_INV_BASE:  inv_base_q = value;
      default:       time_step_q = value[15:0];
    endcase
  endtask

  // result check, receiver stalls and watchdog
  always @(posedge clk_i) begin
    pose_t want;
    logic [175:0] d;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        d = m_axis_tdata;
        if (pose_q.size() == 0) begin
          report("unexpected transfer", d[63:0], 64'd0);
        end else begin
          want = pose_q.pop_front();
          if (d[31:0] != want.x) report("next_x", d[31:0], want.x);
          if (d[63:32] != want.y) report("next_y", d[63:32], want.y);
          if (d[95:64] != want.h) report("next_heading", d[95:64], want.h);
          if (d[120:96] != want.fwd) report("forward_speed", d[120:96], want.fwd);
          if (d[152:121] != want.turn) report("turn_rate", d[152:121], want.turn);
          if (d[168:153] != want.gyro) report("gyro_reading", d[168:153], want.gyro);
          if (d[169] != want.mode) report("auto_mode", d[169], want.mode);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) rx_burst <= !rx_burst;
      rx_stall <= gap_len(rx_burst);
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    pose_t z;
    max_speed_q = 65536;
    inv_base_q = 327680;
    time_step_q = 1092;
    pos_x_q = '0;
    pos_y_q = '0;
    heading_q = '0;
    auto_q = 1'b0;
    btn_was_q = 1'b0;
    key_was_q = 1'b0;
    gyro_q = '0;
    z = '{'0, '0, '0, '0, '0, '0, 1'b0};

    rows.push_back('{mk_tick(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk_tick(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 0, 0,
                             32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF), 1,
                     '{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, '0, '0, '0, 1'b0}});
    rows.push_back('{mk_tick(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk_tick(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 8'd100, 8'd100, 0, 0, 0), 0, z});
    rows.push_back('{mk_tick(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 8'h9C, 8'd100, 0, 0, 0), 0, z});
    // stick beyond full scale
    rows.push_back('{mk_tick(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 8'h7F, 8'h80, 0, 0, 0), 0, z});
    rows.push_back('{mk_tick(OP_ADVANCE, 1, 0, 255, 0, 255, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk_tick(OP_ADVANCE, 1, 0, 255, 1, 255, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk_tick(OP_ADVANCE, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk_tick(OP_ADVANCE, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk_tick(OP_ADVANCE, 1, 0, 0, 0, 200, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk_tick(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 8'd50, 8'hCE, 0, 0, 0), 0, z});
    rows.push_back('{mk_tick(OP_ADVANCE, 1, 1, 90, 0, 30, 1, 8'd60, 8'd20, 0, 0, 0), 0, z});
    foreach (ANGLE_STEP[i]) begin
      if (i < 4) begin
        rows.push_back('{mk_tick(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 0, 0, 32'h00010000,
                                 32'hFFFF0000, {i[1:0], 30'd0} + 32'h20000000 * (i == 3)),
                         0, z});
        rows.push_back('{mk_tick(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 8'd100, 8'd50, 0, 0, 0),
                         0, z});
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_tick(rows[i].t, rows[i].typed, rows[i].r);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          write_reg(CFG_MAX_SPEED, 24'hFFFFFF);
          write_reg(CFG_INV_BASE, 24'hFFFFFF);
          write_reg(CFG_TIME_STEP, 24'h00FFFF);
        end
        2: begin
          write_reg(CFG_MAX_SPEED, 24'd0);
          write_reg(CFG_INV_BASE, 24'd1);
          write_reg(CFG_TIME_STEP, 24'd1);
        end
        3, 4: begin
          write_reg(CFG_MAX_SPEED, 24'($urandom));
          write_reg(CFG_INV_BASE, 24'($urandom_range(1, 24'hFFFFFF)));
          write_reg(CFG_TIME_STEP, 24'($urandom_range(1, 16'hFFFF)));
        end
        default: ;
      endcase
      repeat (RANDOM_ITEMS) send_tick(rand_tick(), 0, z);
    end
    s_axis_tvalid <= 1'b0;

    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* diff_drive_pose_integrator_top.f */
+incdir+hdl
hdl/ddpi_pkg.sv
hdl/ddpi_mul.sv
hdl/ddpi_cordic.sv
hdl/diff_drive_pose_integrator_top.sv
bench/diff_drive_pose_integrator_top_test.sv
